[design/bwcr_pkg.sv]
// ----------------------------------------------------------------------------
// bwcr_pkg
// Shared widths, register codes and the configuration record of the
// bar-width code reader.
// ----------------------------------------------------------------------------
package bwcr_pkg;

  // number of bits in one code word
  localparam int unsigned CODE_BITS = 10;
  localparam int unsigned CNT_W     = $clog2(CODE_BITS + 1);

  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned WORD_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_BAR_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN      = 2'd3;

  // register reset values
  localparam logic [9:0]  WHITE_THRESHOLD_RST = 10'd200;
  localparam logic [15:0] LONG_BAR_COUNT_RST  = 16'd1000;
  localparam logic [7:0]  BASE_SPEED_RST      = 8'd150;
  localparam logic [11:0] STEER_GAIN_RST      = 12'd256;

  typedef struct packed {
    logic [9:0]  white_threshold;
    logic [15:0] long_bar_count;
    logic [7:0]  base_speed;
    logic [11:0] steer_gain_q8;
  } cfg_t;

endpackage

[design/bwcr_steer.sv]
// ----------------------------------------------------------------------------
// bwcr_steer
// Proportional steering: correction = gain * (left - right) / 256, truncated
// toward zero, and both motor duties clamped to 0..255.
// ----------------------------------------------------------------------------
module bwcr_steer import bwcr_pkg::*; (
  input  cfg_t                     cfg_i,
  input  logic signed [POS_W-1:0]  left_position_i,
  input  logic signed [POS_W-1:0]  right_position_i,
  output logic        [DUTY_W-1:0] left_duty_o,
  output logic        [DUTY_W-1:0] right_duty_o
);

  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned GAIN_W = 13;
  localparam int unsigned PROD_W = DIFF_W + GAIN_W;
  localparam int unsigned CORR_W = PROD_W - 8;
  localparam int unsigned SUM_W  = CORR_W + 1;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [CORR_W-1:0] corr;
  logic signed [SUM_W-1:0]  base_x;
  logic signed [SUM_W-1:0]  corr_x;
  logic signed [SUM_W-1:0]  left_sum;
  logic signed [SUM_W-1:0]  right_sum;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [SUM_W-1:0] v);
    logic [DUTY_W-1:0] r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (|v[SUM_W-2:DUTY_W]) begin
      r = '1;
    end else begin
      r = v[DUTY_W-1:0];
    end
    return r;
  endfunction

  assign diff = {left_position_i[POS_W-1], left_position_i}
              - {right_position_i[POS_W-1], right_position_i};
  assign prod = $signed({1'b0, cfg_i.steer_gain_q8}) * diff;

  // arithmetic shift floors; bump negative inexact results toward zero
  assign corr = prod[PROD_W-1:8]
              + CORR_W'(prod[PROD_W-1] && (|prod[7:0]));

  assign base_x    = $signed({(SUM_W-DUTY_W)'(0), cfg_i.base_speed});
  assign corr_x    = {corr[CORR_W-1], corr};
  assign left_sum  = base_x - corr_x;
  assign right_sum = base_x + corr_x;

  assign left_duty_o  = clamp_duty(left_sum);
  assign right_duty_o = clamp_duty(right_sum);

endmodule

[design/bar_width_code_reader_with_steering.sv]
// ----------------------------------------------------------------------------
// bar_width_code_reader_with_steering
// Reads a bar-width code from reflectance samples while steering two motors.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle while in_ready_o is high. A sample is
// captured in an input register, all steering and bar decoding is done in one
// pass of logic, and the result lands in an output register once that register
// is empty or its word is taken. in_ready_o drops only while the output register
// holds a word that is not taken and the input register is full. The bar state
// is updated as a sample moves into the output register, so the next sample
// sees the updated state. After the code is emitted every result is all zero
// until reset. Registers are written at any time through the cfg channel
// (cfg_ready_o is always high) and must be changed only while the block is idle.
module bar_width_code_reader_with_steering import bwcr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DAT_W-1:0]     cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic        [LEVEL_W-1:0] left_level_i,
  input  logic        [LEVEL_W-1:0] right_level_i,
  input  logic signed [POS_W-1:0]   left_position_i,
  input  logic signed [POS_W-1:0]   right_position_i,

  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DUTY_W-1:0]        left_duty_o,
  output logic [DUTY_W-1:0]        right_duty_o,
  output logic                     drive_on_o,
  output logic                     bit_valid_o,
  output logic                     bit_value_o,
  output logic                     code_valid_o,
  output logic [WORD_W-1:0]        code_word_o
);

  localparam int unsigned AVG_W = POS_W + 1;
  localparam int unsigned LEN_W = AVG_W + 1;

  // configuration
  cfg_t cfg_q;

  // input register
  logic                      s1_valid_q, s1_valid_d;
  logic        [LEVEL_W-1:0] s1_left_level_q, s1_right_level_q;
  logic signed [POS_W-1:0]   s1_left_pos_q, s1_right_pos_q;

  // bar state
  logic                      in_white_q, in_white_d;
  logic signed [AVG_W-1:0]   bar_start_q, bar_start_d;
  logic        [CNT_W-1:0]   bits_stored_q, bits_stored_d;
  logic        [CODE_BITS-1:0] code_shift_q, code_shift_d;
  logic                      halted_q, halted_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic [DUTY_W-1:0]         left_duty_q, left_duty_d;
  logic [DUTY_W-1:0]         right_duty_q, right_duty_d;
  logic                      drive_on_q, drive_on_d;
  logic                      bit_valid_q, bit_valid_d;
  logic                      bit_value_q, bit_value_d;
  logic                      code_valid_q, code_valid_d;
  logic [WORD_W-1:0]         code_word_q, code_word_d;

  logic                      in_fire, out_take, s1_fire;
  logic [DUTY_W-1:0]         steer_left, steer_right;
  logic                      white, rise, fall, full, long_bar;
  logic signed [AVG_W-1:0]   pos_sum, avg;
  logic signed [LEN_W-1:0]   bar_len;
  logic [CODE_BITS:0]        shift_ext;
  logic [CODE_BITS+WORD_W-1:0] word_ext;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.white_threshold <= WHITE_THRESHOLD_RST;
      cfg_q.long_bar_count  <= LONG_BAR_COUNT_RST;
      cfg_q.base_speed      <= BASE_SPEED_RST;
      cfg_q.steer_gain_q8   <= STEER_GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WHITE_THRESHOLD: cfg_q.white_threshold <= cfg_data_i[9:0];
        REG_LONG_BAR_COUNT:  cfg_q.long_bar_count  <= cfg_data_i[15:0];
        REG_BASE_SPEED:      cfg_q.base_speed      <= cfg_data_i[7:0];
        REG_STEER_GAIN:      cfg_q.steer_gain_q8   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  assign out_take   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_take;
  assign in_ready_o = !s1_valid_q || out_take;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_left_level_q  <= left_level_i;
      s1_right_level_q <= right_level_i;
      s1_left_pos_q    <= left_position_i;
      s1_right_pos_q   <= right_position_i;
    end
  end

  // --------------------------------------------------------------------------
  // steering and bar decoding
  // --------------------------------------------------------------------------
  bwcr_steer u_steer (
    .cfg_i            (cfg_q),
    .left_position_i  (s1_left_pos_q),
    .right_position_i (s1_right_pos_q),
    .left_duty_o      (steer_left),
    .right_duty_o     (steer_right)
  );

  assign white = (s1_left_level_q > cfg_q.white_threshold)
              || (s1_right_level_q > cfg_q.white_threshold);
  assign rise  = white && !in_white_q;
  assign fall  = !white && in_white_q;
  assign full  = (bits_stored_q == CNT_W'(CODE_BITS));

  // average truncated toward zero: add one to negative sums before halving
  assign pos_sum = {s1_left_pos_q[POS_W-1], s1_left_pos_q}
                 + {s1_right_pos_q[POS_W-1], s1_right_pos_q};
  assign avg     = $signed(pos_sum + AVG_W'(pos_sum[AVG_W-1])) >>> 1;

  assign bar_len  = {avg[AVG_W-1], avg} - {bar_start_q[AVG_W-1], bar_start_q};
  assign long_bar = bar_len > $signed({(LEN_W-16)'(0), cfg_q.long_bar_count});

  assign shift_ext = {code_shift_q, long_bar};
  assign word_ext  = {(WORD_W)'(0), code_shift_q};

  always_comb begin
    in_white_d    = in_white_q;
    bar_start_d   = bar_start_q;
    bits_stored_d = bits_stored_q;
    code_shift_d  = code_shift_q;
    halted_d      = halted_q;
    left_duty_d   = steer_left;
    right_duty_d  = steer_right;
    drive_on_d    = 1'b1;
    bit_valid_d   = 1'b0;
    bit_value_d   = 1'b0;
    code_valid_d  = 1'b0;
    code_word_d   = '0;

    if (halted_q) begin
      left_duty_d  = '0;
      right_duty_d = '0;
      drive_on_d   = 1'b0;
    end else if (rise) begin
      in_white_d  = 1'b1;
      bar_start_d = avg;
    end else if (fall) begin
      in_white_d = 1'b0;
      if (!full) begin
        code_shift_d  = shift_ext[CODE_BITS-1:0];
        bits_stored_d = bits_stored_q + CNT_W'(1);
        bit_valid_d   = 1'b1;
        bit_value_d   = long_bar;
      end else begin
        // emit the code, stop and halt
        code_valid_d  = 1'b1;
        code_word_d   = word_ext[WORD_W-1:0];
        left_duty_d   = '0;
        right_duty_d  = '0;
        drive_on_d    = 1'b0;
        bits_stored_d = '0;
        code_shift_d  = '0;
        bar_start_d   = '0;
        halted_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_white_q    <= 1'b0;
      bar_start_q   <= '0;
      bits_stored_q <= '0;
      code_shift_q  <= '0;
      halted_q      <= 1'b0;
    end else if (s1_fire) begin
      in_white_q    <= in_white_d;
      bar_start_q   <= bar_start_d;
      bits_stored_q <= bits_stored_d;
      code_shift_q  <= code_shift_d;
      halted_q      <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      left_duty_q  <= left_duty_d;
      right_duty_q <= right_duty_d;
      drive_on_q   <= drive_on_d;
      bit_valid_q  <= bit_valid_d;
      bit_value_q  <= bit_value_d;
      code_valid_q <= code_valid_d;
      code_word_q  <= code_word_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_duty_o  = left_duty_q;
  assign right_duty_o = right_duty_q;
  assign drive_on_o   = drive_on_q;
  assign bit_valid_o  = bit_valid_q;
  assign bit_value_o  = bit_value_q;
  assign code_valid_o = code_valid_q;
  assign code_word_o  = code_word_q;

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_stored_q <= CNT_W'(CODE_BITS))
    else $error("bit count beyond code length");

  a_emit_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !halted_q && fall && full) |=> (halted_q && out_valid_q && code_valid_q))
    else $error("code emitted without halting");

  a_code_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && code_valid_q) |-> (!drive_on_q && left_duty_q == '0
                                        && right_duty_q == '0))
    else $error("motors driven on the code word");

  a_bit_xor_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(bit_valid_q && code_valid_q))
    else $error("bit and code in the same word");
`endif

endmodule
